// File: sv/frem_pkg.sv
// Shared types and constants of the frame rate moving-average monitor.
package frem_pkg;

  // Event kinds carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_PAUSE   = 2'd1,
    KIND_MEASURE = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_THR      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 4'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [15:0] SLOW_THR_RST      = 16'd100;
  localparam logic [7:0]  REPORT_PERIOD_RST = 8'd30;

  // Smoothing coefficients in 1/65536 units: 0.95 and 0.05.
  localparam logic [15:0] KEEP_COEF  = 16'd62259;
  localparam logic [11:0] NEW_COEF   = 12'd3277;
  localparam int unsigned COEF_SHIFT = 16;

  // Milliseconds per second, numerator of the fps division.
  localparam logic [9:0]  MS_PER_S   = 10'd1000;
  localparam int unsigned MS_W       = 10;

  localparam int unsigned AVG_W = 32;
  localparam int unsigned FPS_W = 16;
  localparam logic [FPS_W-1:0] FPS_SAT = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch the event and update the counters
    logic mul;        // form both coefficient products
    logic sum;        // add the products into the average
    logic div_start;  // start the fps division
    logic fin;        // take the quotient, update fps extremes
    logic load_out;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic upd_req;    // offered event is a frame end with nonzero time
    logic div_done;   // division finished this cycle
  } status_t;

endpackage

// File: sv/frame_rate_ema_monitor.sv
// Top level of the frame rate monitor with a moving-average frame time.
//
//  Channel   Direction  Sideband       Payload
//  s_axis    in         tuser: kind    tdata: elapsed_ms
//  m_axis    out        tuser: due     tdata: fps, average, extremes and counters
//  cfg       in         write only     index 0 slow threshold, index 1 report period
//
// A frame end with a nonzero time passes through the multiply, sum, start, division and
// finish states before its result is offered; the serial divider retires one quotient bit
// per cycle over FRAC_BITS + 10 numerator bits. Every other event goes straight to output.
// One event is in work at a time; the next is taken once the current result has been
// loaded into the output register, so a stalled output costs at most that register.
// Reset is asynchronous and active low; it clears all statistics and restores the
// register defaults (threshold 100 ms, period 30 frames).
module frame_rate_ema_monitor #(
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Event input.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,   // [15:0] elapsed_ms
  input  logic [1:0]                        s_axis_tuser,   // [1:0] kind
  // Statistics output.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] fps_whole, [47:16] avg_frame_time, [63:48] max_fps, [79:64] min_fps,
  // [111:80] slow_frames, [143:112] frame_total, [175:144] sample_total,
  // [207:176] report_total, [239:208] pause_total, [271:240] measurement_total
  output logic [271:0]                      m_axis_tdata,
  output logic                              m_axis_tuser,   // [0] report_due
  // Configuration writes.
  input  logic                              cfg_we_i,
  input  logic [frem_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [frem_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import frem_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic [15:0] fps_whole;
  logic [31:0] avg_frame_time;
  logic [15:0] max_fps;
  logic [15:0] min_fps;
  logic [31:0] slow_frames;
  logic        report_due;
  logic [31:0] frame_total;
  logic [31:0] sample_total;
  logic [31:0] report_total;
  logic [31:0] pause_total;
  logic [31:0] measurement_total;

  frem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  frem_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .kind_i              (s_axis_tuser),
    .elapsed_i           (s_axis_tdata),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .fps_whole_o         (fps_whole),
    .avg_frame_time_o    (avg_frame_time),
    .max_fps_o           (max_fps),
    .min_fps_o           (min_fps),
    .slow_frames_o       (slow_frames),
    .report_due_o        (report_due),
    .frame_total_o       (frame_total),
    .sample_total_o      (sample_total),
    .report_total_o      (report_total),
    .pause_total_o       (pause_total),
    .measurement_total_o (measurement_total)
  );

  // Fields packed from the lowest bit up, in the order of the port comment.
  assign m_axis_tdata = {measurement_total, pause_total, report_total, sample_total,
                         frame_total, slow_frames, min_fps, max_fps, avg_frame_time,
                         fps_whole};
  assign m_axis_tuser = report_due;

endmodule

// File: sv/frem_div.sv
// Restoring divider of a constant numerator by the smoothed frame time, one bit per cycle.
module frem_div #(
  parameter int unsigned NUM_W = 26
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [frem_pkg::AVG_W-1:0]    divisor_i,
  input  logic [NUM_W-1:0]              numer_i,
  output logic                          done_o,
  output logic [NUM_W-1:0]              quot_o
);
  import frem_pkg::*;

  localparam int unsigned STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  logic [AVG_W-1:0]    div_q;
  logic [AVG_W-1:0]    rem_q;
  logic [NUM_W-1:0]    shf_q;
  logic [AVG_W:0]      rem_sh;
  logic                ge;

  assign rem_sh = {rem_q, shf_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - STEP_W'(1);
        end
      end
    end
  end

  // The numerator shifts out of the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      shf_q <= numer_i;
    end else if (busy_q) begin
      rem_q <= ge ? AVG_W'(rem_sh - {1'b0, div_q}) : AVG_W'(rem_sh);
      shf_q <= {shf_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = shf_q;

endmodule

// File: sv/frem_datapath.sv
// Datapath of the monitor: statistics registers, smoothing products, divider and result register.
module frem_datapath #(
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  frem_pkg::cmd_t                    cmd_i,
  output frem_pkg::status_t                 status_o,
  input  logic [1:0]                        kind_i,
  input  logic [15:0]                       elapsed_i,
  input  logic                              cfg_we_i,
  input  logic [frem_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [frem_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic [15:0]                       fps_whole_o,
  output logic [31:0]                       avg_frame_time_o,
  output logic [15:0]                       max_fps_o,
  output logic [15:0]                       min_fps_o,
  output logic [31:0]                       slow_frames_o,
  output logic                              report_due_o,
  output logic [31:0]                       frame_total_o,
  output logic [31:0]                       sample_total_o,
  output logic [31:0]                       report_total_o,
  output logic [31:0]                       pause_total_o,
  output logic [31:0]                       measurement_total_o
);
  import frem_pkg::*;

  localparam int unsigned KEEP_P_W = AVG_W + 16;
  localparam int unsigned NEW_P_W  = 16 + 12;
  localparam int unsigned NEW_SH_W = NEW_P_W + FRAC_BITS;
  localparam int unsigned NEW_T_W  = NEW_SH_W - COEF_SHIFT;
  localparam int unsigned SUM_W    = ((NEW_T_W > AVG_W) ? NEW_T_W : AVG_W) + 1;
  localparam int unsigned NUM_W    = MS_W + FRAC_BITS;
  localparam logic [NUM_W-1:0] NUMER = NUM_W'(MS_PER_S) << FRAC_BITS;

  kind_e                 kind;
  logic [15:0]           slow_thr_q;
  logic [7:0]            period_q;
  logic [15:0]           elapsed_q;
  logic [AVG_W-1:0]      avg_q;
  logic [FPS_W-1:0]      fps_q;
  logic [FPS_W-1:0]      max_q;
  logic [FPS_W-1:0]      min_q;
  logic [COUNT_BITS-1:0] frame_cnt_q;
  logic [COUNT_BITS-1:0] sample_cnt_q;
  logic [COUNT_BITS-1:0] slow_cnt_q;
  logic [COUNT_BITS-1:0] report_cnt_q;
  logic [COUNT_BITS-1:0] pause_cnt_q;
  logic [COUNT_BITS-1:0] measure_cnt_q;
  logic [7:0]            phase_q;
  logic                  due_q;
  logic [7:0]            phase_d;
  logic                  period_done;
  logic                  nonzero;
  logic [KEEP_P_W-1:0]   keep_p_q;
  logic [NEW_P_W-1:0]    new_p_q;
  logic [NEW_SH_W-1:0]   new_sh;
  logic [SUM_W-1:0]      sum;
  logic                  div_done;
  logic [NUM_W-1:0]      quot;
  logic [FPS_W-1:0]      fps_d;

  assign kind        = kind_e'(kind_i);
  assign nonzero     = elapsed_i != 16'd0;
  assign phase_d     = phase_q + 8'd1;
  assign period_done = phase_d >= period_q;

  assign status_o.upd_req  = (kind == KIND_FRAME) && nonzero;
  assign status_o.div_done = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_thr_q <= SLOW_THR_RST;
      period_q   <= REPORT_PERIOD_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SLOW_THR) begin
        slow_thr_q <= cfg_wdata_i[15:0];
      end else if (cfg_idx_i == REG_REPORT_PERIOD) begin
        period_q <= cfg_wdata_i[7:0];
      end
    end
  end

  // Event counters, all updated in the cycle the event is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cnt_q   <= '0;
      sample_cnt_q  <= '0;
      slow_cnt_q    <= '0;
      report_cnt_q  <= '0;
      pause_cnt_q   <= '0;
      measure_cnt_q <= '0;
      phase_q       <= '0;
      due_q         <= 1'b0;
    end else if (cmd_i.accept) begin
      due_q <= 1'b0;
      unique case (kind)
        KIND_FRAME: begin
          frame_cnt_q  <= frame_cnt_q + COUNT_BITS'(1);
          sample_cnt_q <= sample_cnt_q + COUNT_BITS'(1);
          phase_q      <= period_done ? 8'd0 : phase_d;
          due_q        <= period_done && nonzero;
          if (nonzero && (elapsed_i > slow_thr_q)) begin
            slow_cnt_q <= slow_cnt_q + COUNT_BITS'(1);
          end
          if (nonzero && period_done) begin
            report_cnt_q <= report_cnt_q + COUNT_BITS'(1);
          end
        end
        KIND_PAUSE: begin
          pause_cnt_q <= pause_cnt_q + COUNT_BITS'(1);
        end
        KIND_MEASURE: begin
          measure_cnt_q <= measure_cnt_q + COUNT_BITS'(1);
        end
        KIND_CLEAR: begin
          sample_cnt_q  <= '0;
          slow_cnt_q    <= '0;
          report_cnt_q  <= '0;
          pause_cnt_q   <= '0;
          measure_cnt_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      elapsed_q <= elapsed_i;
    end
    if (cmd_i.mul) begin
      keep_p_q <= KEEP_P_W'(avg_q) * KEEP_P_W'(KEEP_COEF);
      new_p_q  <= NEW_P_W'(elapsed_q) * NEW_P_W'(NEW_COEF);
    end
  end

  // The new sample enters at FRAC_BITS fraction bits before the coefficient scaling.
  assign new_sh = {new_p_q, {FRAC_BITS{1'b0}}};
  assign sum    = SUM_W'(keep_p_q[KEEP_P_W-1:COEF_SHIFT])
                + SUM_W'(new_sh[NEW_SH_W-1:COEF_SHIFT]);

  frem_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .divisor_i (avg_q),
    .numer_i   (NUMER),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_comb begin
    if (avg_q == '0) begin
      fps_d = FPS_SAT;
    end else if (|quot[NUM_W-1:FPS_W]) begin
      fps_d = FPS_SAT;
    end else begin
      fps_d = quot[FPS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
      fps_q <= '0;
      max_q <= '0;
      min_q <= '0;
    end else begin
      if (cmd_i.sum) begin
        avg_q <= (|sum[SUM_W-1:AVG_W]) ? {AVG_W{1'b1}} : sum[AVG_W-1:0];
      end
      if (cmd_i.fin) begin
        fps_q <= fps_d;
        if (fps_d > max_q) begin
          max_q <= fps_d;
        end
        if ((min_q == '0) || (fps_d < min_q)) begin
          min_q <= fps_d;
        end
      end else if (cmd_i.accept && (kind == KIND_CLEAR)) begin
        max_q <= '0;
        min_q <= '0;
      end
    end
  end

  // Result register: a snapshot of the statistics once the event is done.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      fps_whole_o         <= fps_q;
      avg_frame_time_o    <= avg_q;
      max_fps_o           <= max_q;
      min_fps_o           <= min_q;
      slow_frames_o       <= 32'(slow_cnt_q);
      report_due_o        <= due_q;
      frame_total_o       <= 32'(frame_cnt_q);
      sample_total_o      <= 32'(sample_cnt_q);
      report_total_o      <= 32'(report_cnt_q);
      pause_total_o       <= 32'(pause_cnt_q);
      measurement_total_o <= 32'(measure_cnt_q);
    end
  end

`ifndef SYNTHESIS
  a_min_not_above_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (min_q != '0) |-> (min_q <= max_q))
    else $error("minimum fps above maximum fps");

  a_zero_avg_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin && (avg_q == '0)) |=> (fps_q == FPS_SAT))
    else $error("zero average did not saturate fps");

  a_due_only_on_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && (kind != KIND_FRAME)) |=> !due_q)
    else $error("report flag raised by a non-frame event");
`endif

endmodule

// File: sv/frem_ctrl.sv
// Controller state machine sequencing event intake, averaging, division and result hand-off.
module frem_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  frem_pkg::status_t  status_i,
  output frem_pkg::cmd_t     cmd_o
);
  import frem_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul       = state_q == ST_MUL;
    cmd_o.sum       = state_q == ST_SUM;
    cmd_o.div_start = state_q == ST_START;
    cmd_o.fin       = state_q == ST_FIN;
    cmd_o.load_out  = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A new result takes precedence over the transfer of the old one.
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= status_i.upd_req ? ST_MUL : ST_OUT;
          end
        end
        ST_MUL:   state_q <= ST_SUM;
        ST_SUM:   state_q <= ST_START;
        ST_START: state_q <= ST_DIV;
        ST_DIV: begin
          if (status_i.div_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN:   state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register loaded while a result is still pending");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the division state");

  a_update_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && status_i.upd_req) |=> (state_q == ST_MUL))
    else $error("frame end with nonzero time skipped the average update");
`endif

endmodule
